>>> rtl/core/bc3_pkg.sv
package bc3_pkg;

	localparam int unsigned TEXELS  = 16;
	localparam int unsigned IDX_W   = 4;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TEXELS - 1);

	// bit positions inside the two block halves
	localparam int unsigned ALPHA_CODE_LSB = 16;
	localparam int unsigned COLOR_CODE_LSB = 32;

	// reciprocal constants for the truncating constant divides
	localparam int unsigned W5_MUL  = 255 * 8457;   // c*255/31, shift 18
	localparam int unsigned W6_MUL  = 255 * 16645;  // c*255/63, shift 20
	localparam int unsigned DIV3_MUL = 683;         // shift 11
	localparam int unsigned DIV7_MUL = 2341;        // shift 14
	localparam int unsigned DIV5_MUL = 3277;        // shift 14

	typedef enum logic [1:0] {
		ALPHA_CALC,
		ALPHA_ZERO,
		ALPHA_FULL
	} alpha_ovr_t;

	// one texel issued from the held block into the pipeline
	typedef struct packed {
		logic             valid;
		logic [7:0]       alpha0;
		logic [7:0]       alpha1;
		logic [2:0]       alpha_code;
		logic [15:0]      color0;
		logic [15:0]      color1;
		logic [1:0]       color_code;
		logic [IDX_W-1:0] index;
	} texel_req_t;

endpackage

>>> rtl/core/bc3_seq.sv
module bc3_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [63:0]         alpha_half,
	input  logic [63:0]         color_half,
	output bc3_pkg::texel_req_t req,
	input  logic                req_ready
);
	import bc3_pkg::*;

	logic             blk_v_q;
	logic [IDX_W-1:0] cnt_q;
	logic [63:0]      alpha_q;
	logic [63:0]      color_q;
	logic             issue;
	logic             last_issue;
	logic             load;

	assign issue      = blk_v_q && req_ready;
	assign last_issue = issue && (cnt_q == LAST_IDX);
	// next block loads on the same edge the last texel of this one leaves
	assign in_ready   = !blk_v_q || last_issue;
	assign load       = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_v_q <= 1'b0;
			cnt_q   <= '0;
		end else if (load) begin
			blk_v_q <= 1'b1;
			cnt_q   <= '0;
		end else if (issue) begin
			blk_v_q <= !last_issue;
			cnt_q   <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			alpha_q <= alpha_half;
			color_q <= color_half;
		end
	end

	always_comb begin
		req.valid      = blk_v_q;
		req.alpha0     = alpha_q[7:0];
		req.alpha1     = alpha_q[15:8];
		req.alpha_code = alpha_q[ALPHA_CODE_LSB + 3 * cnt_q +: 3];
		req.color0     = color_q[15:0];
		req.color1     = color_q[31:16];
		req.color_code = color_q[COLOR_CODE_LSB + 2 * cnt_q +: 2];
		req.index      = cnt_q;
	end

endmodule

>>> rtl/core/bc3_pipe.sv
module bc3_pipe (
	input  logic                clk,
	input  logic                arst_n,
	input  bc3_pkg::texel_req_t req,
	output logic                req_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [31:0]         texel,
	output logic [3:0]          texel_index,
	output logic                last
);
	import bc3_pkg::*;

	function automatic logic [7:0] widen5(input logic [4:0] c);
		logic [26:0] p;
		p = 27'(c) * 27'(W5_MUL);
		return p[25:18];
	endfunction

	function automatic logic [7:0] widen6(input logic [5:0] c);
		logic [28:0] p;
		p = 29'(c) * 29'(W6_MUL);
		return p[27:20];
	endfunction

	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [18:0] p;
		p = 19'(x) * 19'(DIV3_MUL);
		return p[18:11];
	endfunction

	function automatic logic [7:0] div7(input logic [10:0] x);
		logic [21:0] p;
		p = 22'(x) * 22'(DIV7_MUL);
		return p[21:14];
	endfunction

	function automatic logic [7:0] div5(input logic [10:0] x);
		logic [21:0] p;
		p = 22'(x) * 22'(DIV5_MUL);
		return p[21:14];
	endfunction

	// stage 1: widened endpoints and interpolation weights
	logic             v_s1;
	logic [7:0]       e0_s1 [3];
	logic [7:0]       e1_s1 [3];
	logic [1:0]       cw0_s1, cw1_s1;
	logic [7:0]       a0_s1, a1_s1;
	logic [2:0]       aw0_s1, aw1_s1;
	logic             adiv7_s1;
	alpha_ovr_t       aovr_s1;
	logic [IDX_W-1:0] idx_s1;

	// stage 2: weighted sums
	logic             v_s2;
	logic [9:0]       csum_s2 [3];
	logic [10:0]      asum_s2;
	logic             adiv7_s2;
	alpha_ovr_t       aovr_s2;
	logic [IDX_W-1:0] idx_s2;

	// stage 3: divided result, also the output register
	logic             v_s3;
	logic [31:0]      texel_s3;
	logic [IDX_W-1:0] idx_s3;

	logic rdy_s1, rdy_s2, rdy_s3;

	assign rdy_s3    = !v_s3 || out_ready;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign req_ready = rdy_s1;

	// weight selection for both parts
	logic [1:0] cw0, cw1;
	logic [2:0] aw0, aw1;
	logic       mode8;
	alpha_ovr_t aovr;

	always_comb begin
		case (req.color_code)
			2'd0:    begin cw0 = 2'd3; cw1 = 2'd0; end
			2'd1:    begin cw0 = 2'd0; cw1 = 2'd3; end
			2'd2:    begin cw0 = 2'd2; cw1 = 2'd1; end
			default: begin cw0 = 2'd1; cw1 = 2'd2; end
		endcase
	end

	assign mode8 = req.alpha0 > req.alpha1;

	always_comb begin
		aovr = ALPHA_CALC;
		if (mode8) begin
			case (req.alpha_code)
				3'd0:    begin aw0 = 3'd7; aw1 = 3'd0; end
				3'd1:    begin aw0 = 3'd0; aw1 = 3'd7; end
				default: begin
					aw0 = 3'(4'd8 - {1'b0, req.alpha_code});
					aw1 = req.alpha_code - 3'd1;
				end
			endcase
		end else begin
			case (req.alpha_code) inside
				3'd0:         begin aw0 = 3'd5; aw1 = 3'd0; end
				3'd1:         begin aw0 = 3'd0; aw1 = 3'd5; end
				[3'd2:3'd5]:  begin
					aw0 = 3'd6 - req.alpha_code;
					aw1 = req.alpha_code - 3'd1;
				end
				3'd6:         begin aw0 = 3'd0; aw1 = 3'd0; aovr = ALPHA_ZERO; end
				default:      begin aw0 = 3'd0; aw1 = 3'd0; aovr = ALPHA_FULL; end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= req.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && req.valid) begin
			// channel order red, green, blue
			e0_s1[0] <= widen5(req.color0[15:11]);
			e0_s1[1] <= widen6(req.color0[10:5]);
			e0_s1[2] <= widen5(req.color0[4:0]);
			e1_s1[0] <= widen5(req.color1[15:11]);
			e1_s1[1] <= widen6(req.color1[10:5]);
			e1_s1[2] <= widen5(req.color1[4:0]);
			cw0_s1   <= cw0;
			cw1_s1   <= cw1;
			a0_s1    <= req.alpha0;
			a1_s1    <= req.alpha1;
			aw0_s1   <= aw0;
			aw1_s1   <= aw1;
			adiv7_s1 <= mode8;
			aovr_s1  <= aovr;
			idx_s1   <= req.index;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			for (int k = 0; k < 3; k++) begin
				csum_s2[k] <= 10'(e0_s1[k]) * 10'(cw0_s1) + 10'(e1_s1[k]) * 10'(cw1_s1);
			end
			asum_s2  <= 11'(a0_s1) * 11'(aw0_s1) + 11'(a1_s1) * 11'(aw1_s1);
			adiv7_s2 <= adiv7_s1;
			aovr_s2  <= aovr_s1;
			idx_s2   <= idx_s1;
		end
	end

	logic [7:0] alpha_val;

	always_comb begin
		case (aovr_s2)
			ALPHA_CALC: alpha_val = adiv7_s2 ? div7(asum_s2) : div5(asum_s2);
			ALPHA_ZERO: alpha_val = 8'h00;
			ALPHA_FULL: alpha_val = 8'hFF;
			default:    alpha_val = 8'h00;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			texel_s3 <= {alpha_val, div3(csum_s2[2]), div3(csum_s2[1]), div3(csum_s2[0])};
			idx_s3   <= idx_s2;
		end
	end

	assign out_valid   = v_s3;
	assign texel       = texel_s3;
	assign texel_index = idx_s3;
	assign last        = (idx_s3 == LAST_IDX);

endmodule

>>> rtl/core/bc3_texture_block_decoder_unit.sv
// bc3 / dxt5 block decoder. one word on the input side is a whole 16-byte
// compressed 4x4 block (alpha_half = bytes 0-7, color_half = bytes 8-15, both
// little-endian); the output side gives the sixteen decoded texels of that
// block in row-major order, one rgba8888 word each (red in bits 7:0, alpha in
// 31:24), with texel_index = row*4 + column and last set on texel 15. color
// endpoints are widened from rgb565 with truncating c*255/31 and c*255/63,
// color is always four-color mode with truncating thirds; alpha is 8-level
// when alpha0 > alpha1, else 6-level with code 6 = 0 and code 7 = 255.
// throughput: one texel per cycle while out_ready is high, set by the
// sequencer that walks the held block one texel per cycle; the next block is
// taken on the same edge its predecessor's last texel enters the pipeline,
// so back-to-back blocks stream with no gap. the first texel of a block is
// registered through the widen, weighted-sum and constant-divide stages
// before it shows on the outputs. both sides stall freely; out_ready low holds
// the pipeline without losing or repeating texels.
module bc3_texture_block_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] alpha_half,
	input  logic [63:0] color_half,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] texel,
	output logic [3:0]  texel_index,
	output logic        last
);
	import bc3_pkg::*;

	texel_req_t req;
	logic       req_ready;

	// holds the block and issues one texel per cycle while req_ready is high
	bc3_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.alpha_half (alpha_half),
		.color_half (color_half),
		.req        (req),
		.req_ready  (req_ready)
	);

	// three-stage texel pipeline, last stage doubles as output register
	bc3_pipe u_pipe (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.req_ready   (req_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.texel       (texel),
		.texel_index (texel_index),
		.last        (last)
	);

endmodule

>>> rtl/core/bc3_checker.sv
module bc3_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] texel,
	input logic [3:0]  texel_index,
	input logic        last
);

	// a stalled output word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(texel) && $stable(texel_index))
		else $error("output word changed while stalled");

	// last marks texel 15 and only texel 15
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (texel_index == 4'd15)))
		else $error("last flag does not match texel index");

	// a freshly taken block keeps the input not ready in the cycle right after
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after block accepted");

	// texels leave in order: after a non-last texel the next shown is its successor
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last ##1 out_valid
			|-> texel_index == $past(texel_index) + 4'd1)
		else $error("texel index skipped or repeated");

endmodule

bind bc3_texture_block_decoder_unit bc3_checker u_bc3_checker (.*);

>>> verif/tb_bc3_texture_block_decoder_unit.sv
module tb_bc3_texture_block_decoder_unit;

	// bound on the whole run, well above the slowest legal schedule
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned RANDOM_BLOCKS = 310;
	// long receiver hold so the pipeline and the input side back up
	localparam int unsigned HOLD_CYCLES  = 160;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [63:0] alpha_half = '0;
	logic [63:0] color_half = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] texel;
	logic [3:0]  texel_index;
	logic        last;

	bc3_texture_block_decoder_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.alpha_half  (alpha_half),
		.color_half  (color_half),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.texel       (texel),
		.texel_index (texel_index),
		.last        (last)
	);

	// one decoded texel as it should leave the block
	typedef struct {
		logic [31:0]              rgba;
		logic [bc3_pkg::IDX_W-1:0] idx;
		logic                     is_last;
	} texel_word_t;

	// holds the texels each accepted block must produce, in order
	class texel_scoreboard;
		localparam logic [1:0] SEL_C0       = 2'd0;
		localparam logic [1:0] SEL_C1       = 2'd1;
		localparam logic [1:0] SEL_NEAR_C0  = 2'd2;
		localparam logic [1:0] SEL_NEAR_C1  = 2'd3;
		localparam logic [2:0] ACODE_A0     = 3'd0;
		localparam logic [2:0] ACODE_A1     = 3'd1;
		localparam logic [2:0] ACODE_ZERO   = 3'd6;
		localparam logic [2:0] ACODE_OPAQUE = 3'd7;

		texel_word_t pending[$];
		int unsigned errors;
		int unsigned blocks_noted;
		int unsigned texels_checked;
		int unsigned six_level_blocks;

		function logic [7:0] expand5(logic [4:0] v);
			int unsigned w;
			w = v;
			return 8'((w * 255) / 31);
		endfunction

		function logic [7:0] expand6(logic [5:0] v);
			int unsigned w;
			w = v;
			return 8'((w * 255) / 63);
		endfunction

		// four-color palette entry for one channel, thirds truncate
		function logic [7:0] palette_chan(logic [7:0] e0, logic [7:0] e1, logic [1:0] sel);
			int unsigned x0, x1;
			x0 = e0;
			x1 = e1;
			case (sel)
				SEL_C0:      return e0;
				SEL_C1:      return e1;
				SEL_NEAR_C0: return 8'((2 * x0 + x1) / 3);
				default:     return 8'((x0 + 2 * x1) / 3);
			endcase
		endfunction

		// eight levels when a0 > a1, else six levels plus fixed 0 and 255
		function logic [7:0] alpha_level(logic [7:0] a0, logic [7:0] a1, logic [2:0] code);
			int unsigned x0, x1, k;
			x0 = a0;
			x1 = a1;
			k = code;
			if (code == ACODE_A0)
				return a0;
			if (code == ACODE_A1)
				return a1;
			if (a0 > a1)
				return 8'((x0 * (8 - k) + x1 * (k - 1)) / 7);
			if (code == ACODE_ZERO)
				return 8'h00;
			if (code == ACODE_OPAQUE)
				return 8'hFF;
			return 8'((x0 * (6 - k) + x1 * (k - 1)) / 5);
		endfunction

		function void note_block(logic [63:0] ah, logic [63:0] ch);
			logic [15:0] c0, c1;
			logic [7:0]  r0, g0, b0, r1, g1, b1;
			logic [1:0]  csel;
			logic [2:0]  acode;
			texel_word_t w;
			c0 = ch[15:0];
			c1 = ch[31:16];
			r0 = expand5(c0[15:11]);
			g0 = expand6(c0[10:5]);
			b0 = expand5(c0[4:0]);
			r1 = expand5(c1[15:11]);
			g1 = expand6(c1[10:5]);
			b1 = expand5(c1[4:0]);
			if (ah[7:0] <= ah[15:8])
				six_level_blocks++;
			for (int t = 0; t < bc3_pkg::TEXELS; t++) begin
				csel  = ch[bc3_pkg::COLOR_CODE_LSB + 2 * t +: 2];
				acode = ah[bc3_pkg::ALPHA_CODE_LSB + 3 * t +: 3];
				w.rgba = {alpha_level(ah[7:0], ah[15:8], acode),
					palette_chan(b0, b1, csel),
					palette_chan(g0, g1, csel),
					palette_chan(r0, r1, csel)};
				w.idx = t[bc3_pkg::IDX_W-1:0];
				w.is_last = (w.idx == bc3_pkg::LAST_IDX);
				pending.push_back(w);
			end
			blocks_noted++;
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task check_texel(logic [31:0] rgba, logic [3:0] idx, logic is_last);
			texel_word_t want;
			if (pending.size() == 0) begin
				report($sformatf("texel word %h index %0d with none outstanding", rgba, idx));
				return;
			end
			want = pending.pop_front();
			texels_checked++;
			if (rgba !== want.rgba)
				report($sformatf("texel %0d rgba %h, want %h", want.idx, rgba, want.rgba));
			if (idx !== want.idx)
				report($sformatf("texel_index %0d, want %0d", idx, want.idx));
			if (is_last !== want.is_last)
				report($sformatf("last %b on texel %0d, want %b", is_last, want.idx,
					want.is_last));
		endtask
	endclass

	texel_scoreboard sb;
	int unsigned cycles = 0;
	int unsigned blocks_sent = 0;
	int unsigned texels_taken = 0;
	bit send_fast = 1'b0;
	bit recv_fast = 1'b0;

	initial begin
		forever #4 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL bc3_texture_block_decoder_unit");
			$finish;
		end
	end

	// offer one block, hold it until taken, then log it for prediction
	task send_block(input logic [63:0] ah, input logic [63:0] ch);
		int unsigned gap;
		// runs of back-to-back blocks now and then
		if (blocks_sent % 24 == 0)
			send_fast = ($urandom_range(0, 2) == 0);
		gap = send_fast ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		alpha_half <= ah;
		color_half <= ch;
		do @(posedge clk); while (!in_ready);
		sb.note_block(ah, ch);
		blocks_sent++;
	endtask

	// consumer side: random stalls, a couple of long holds, check every word
	task receive_loop();
		int unsigned stall;
		forever begin
			if (texels_taken % 40 == 0)
				recv_fast = ($urandom_range(0, 2) == 0);
			if (texels_taken == 48 || texels_taken == 3000)
				stall = HOLD_CYCLES;
			else
				stall = recv_fast ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_texel(texel, texel_index, last);
			texels_taken++;
		end
	endtask

	// alpha codes walk through all eight values starting at off
	function logic [47:0] alpha_codes(int unsigned off);
		logic [47:0] v;
		for (int t = 0; t < bc3_pkg::TEXELS; t++)
			v[3 * t +: 3] = 3'((t + off) % 8);
		return v;
	endfunction

	function logic [31:0] color_codes(int unsigned off);
		logic [31:0] v;
		for (int t = 0; t < bc3_pkg::TEXELS; t++)
			v[2 * t +: 2] = 2'((t + off) % 4);
		return v;
	endfunction

	function logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task run_directed();
		// all-zero and all-one blocks
		send_block(64'h0, 64'h0);
		send_block('1, '1);
		// eight-level alpha, primary and magenta color endpoints, every code in each slot
		send_block({alpha_codes(0), 8'd40, 8'd200}, {color_codes(0), 16'h001F, 16'hF800});
		send_block({alpha_codes(3), 8'd40, 8'd200}, {color_codes(1), 16'hF81F, 16'h07E0});
		// six-level alpha, codes 6 and 7 give the fixed values; the last one is eight-level
		send_block({alpha_codes(0), 8'd200, 8'd40}, {color_codes(2), 16'hFFFF, 16'h0000});
		send_block({alpha_codes(5), 8'd200, 8'd40}, {color_codes(3), 16'h0000, 16'hFFFF});
		send_block({alpha_codes(0), 8'd255, 8'd0}, {color_codes(3), 16'h0000, 16'hFFFF});
		send_block({alpha_codes(2), 8'd0, 8'd255}, {color_codes(0), 16'h1234, 16'h1234});
		// equal alpha endpoints fall into six-level mode; 255 over 254 is eight-level
		send_block({alpha_codes(1), 8'd77, 8'd77}, {color_codes(0), 16'h7BEF, 16'h8410});
		send_block({alpha_codes(6), 8'd254, 8'd255}, {color_codes(1), 16'h0020, 16'h0001});
		send_block({alpha_codes(7), 8'd0, 8'd0}, {color_codes(2), 16'h0000, 16'h0800});
		send_block({alpha_codes(4), 8'd255, 8'd255}, {32'(rand64()), 16'hFFFF, 16'hFFFF});
		// color0 below or above color1 still decodes four-color
		send_block({alpha_codes(1), 8'd1, 8'd0}, {color_codes(1), 16'hFFFF, 16'h0001});
		send_block({48'(rand64()), 8'd128, 8'd127}, {color_codes(2), 16'hF800, 16'h001F});
		send_block({48'(rand64()), 8'd127, 8'd128}, {color_codes(3), 16'h07E0, 16'hF81F});
		send_block({48'(rand64()), 8'd255, 8'd0}, {32'(rand64()), 16'h0000, 16'hFFFF});
	endtask

	// random blocks, some fully random, others biased toward each alpha mode, equal endpoints and extremes
	task pick_block(output logic [63:0] ah, output logic [63:0] ch);
		int unsigned lo;
		logic [15:0] ext[4];
		ext[0] = 16'h0000;
		ext[1] = 16'hFFFF;
		ext[2] = 16'h00FF;
		ext[3] = 16'hFF00;
		ah = rand64();
		ch = rand64();
		case ($urandom_range(0, 9))
			3, 4: begin
				lo = $urandom_range(0, 254);
				ah[7:0]  = 8'($urandom_range(lo + 1, 255));
				ah[15:8] = 8'(lo);
			end
			5, 6: begin
				lo = $urandom_range(0, 255);
				ah[7:0]  = 8'(lo);
				ah[15:8] = 8'($urandom_range(lo, 255));
			end
			7: ah[15:8] = ah[7:0];
			8: begin
				ah[15:0]  = ext[$urandom_range(0, 3)];
				ch[15:0]  = ext[$urandom_range(0, 3)];
				ch[31:16] = ext[$urandom_range(0, 3)];
			end
			9: ch[31:16] = ch[15:0];
			default: ;
		endcase
	endtask

	initial begin
		logic [63:0] ah, ch;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			receive_loop();
		join_none
		run_directed();
		for (int n = 0; n < RANDOM_BLOCKS; n++) begin
			pick_block(ah, ch);
			send_block(ah, ch);
		end
		in_valid <= 1'b0;
		// drain, then give the pipeline time to show any stray word
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		$display("decoded %0d blocks (%0d in six-level alpha), %0d texels checked",
			sb.blocks_noted, sb.six_level_blocks, sb.texels_checked);
		$display("random stalls on both sides, two long output holds, %0d mismatches",
			sb.errors);
		if (sb.errors == 0)
			$display("PASS bc3_texture_block_decoder_unit");
		else
			$display("FAIL bc3_texture_block_decoder_unit");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/bc3_pkg.sv
rtl/core/bc3_seq.sv
rtl/core/bc3_pipe.sv
rtl/core/bc3_texture_block_decoder_unit.sv
rtl/core/bc3_checker.sv
verif/tb_bc3_texture_block_decoder_unit.sv
